### rtl/cwq_pkg.sv
// ----------------------------------------------------------------------------
// cwq_pkg: shared types and constants of the coalescing work queue
// Item count, field widths, operation codes and the command that travels
// from the front end to the execution back end.
// ----------------------------------------------------------------------------
`default_nettype none

package cwq_pkg;

  localparam int NUM_ITEMS = 16;                      // 2 .. 16
  localparam int CNT_W     = $clog2(NUM_ITEMS + 1);   // pending count
  localparam int ID_W      = 4;                       // work_id / run_id field
  localparam int PEND_W    = 5;                       // pending_total field
  localparam int CTR_W     = 32;                      // statistics counters
  localparam int CQ_DEPTH  = 2;                       // command queue entries
  localparam int CQ_PTR_W  = (CQ_DEPTH > 1) ? $clog2(CQ_DEPTH) : 1;
  localparam int CQ_CNT_W  = $clog2(CQ_DEPTH + 1);

  typedef enum logic [1:0] {
    OP_QUEUE  = 2'd0,
    OP_CANCEL = 2'd1,
    OP_DRAIN  = 2'd2,
    OP_NOP    = 2'd3
  } cwq_op_e;

  typedef struct packed {
    cwq_op_e               op;
    logic [ID_W-1:0]       id;
    logic [NUM_ITEMS-1:0]  id_oh;   // one-hot item select, zero when out of range
  } cwq_cmd_t;

endpackage

`default_nettype wire

### rtl/coalescing_work_queue.sv
// ----------------------------------------------------------------------------
// coalescing_work_queue: deduplicating FIFO of work item numbers
// Queue, cancel and drain of pending work items with per-item run counts
// and queued / executed statistics.
// ----------------------------------------------------------------------------
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+-----------------------------
//  in      | input     | in_valid_i/in_ready_o  | opcode_i, work_id_i
//  out     | output    | out_valid_o/out_ready_i| run_valid_o .. last_o
//
//  Queue, cancel and the unused opcode each complete in a single back-end
//  step; a drain dispatches one pending item per step (a single step when
//  nothing is pending). The back end retires one step per cycle unless a
//  stalled output holds it; the two-entry command queue lets the input side
//  keep accepting until it fills while a drain or a stalled output holds.
//  A result passes the command queue and the output register in turn.
//  Reset clears pending bits, run counts and counters at once.
// ----------------------------------------------------------------------------
`default_nettype none

module coalescing_work_queue (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [1:0]                    opcode_i,
  input  wire logic [cwq_pkg::ID_W-1:0]      work_id_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic                               run_valid_o,
  output logic [cwq_pkg::ID_W-1:0]           run_id_o,
  output logic                               changed_o,
  output logic [cwq_pkg::PEND_W-1:0]         pending_total_o,
  output logic [cwq_pkg::CTR_W-1:0]          item_runs_o,
  output logic [cwq_pkg::CTR_W-1:0]          queued_total_o,
  output logic [cwq_pkg::CTR_W-1:0]          executed_total_o,
  output logic                               last_o
);

  logic               cmd_valid;
  logic               cmd_pop;
  cwq_pkg::cwq_cmd_t  cmd;

  cwq_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .opcode_i    (opcode_i),
    .work_id_i   (work_id_i),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_pop_i   (cmd_pop)
  );

  cwq_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_valid_i      (cmd_valid),
    .cmd_i            (cmd),
    .cmd_pop_o        (cmd_pop),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .run_valid_o      (run_valid_o),
    .run_id_o         (run_id_o),
    .changed_o        (changed_o),
    .pending_total_o  (pending_total_o),
    .item_runs_o      (item_runs_o),
    .queued_total_o   (queued_total_o),
    .executed_total_o (executed_total_o),
    .last_o           (last_o)
  );

endmodule

`default_nettype wire

### rtl/cwq_front.sv
// ----------------------------------------------------------------------------
// cwq_front: input acceptance and command queue
// Decodes each input transaction into a command with a one-hot item select
// and holds it in a short queue until the back end retires it.
// ----------------------------------------------------------------------------
`default_nettype none

module cwq_front (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      in_valid_i,
  output logic                           in_ready_o,
  input  wire logic [1:0]                opcode_i,
  input  wire logic [cwq_pkg::ID_W-1:0]  work_id_i,
  output logic                           cmd_valid_o,
  output cwq_pkg::cwq_cmd_t              cmd_o,
  input  wire logic                      cmd_pop_i
);

  cwq_pkg::cwq_cmd_t                     cq_q [cwq_pkg::CQ_DEPTH];
  cwq_pkg::cwq_cmd_t                     new_cmd;
  logic [cwq_pkg::CQ_PTR_W-1:0]          wr_ptr_q, rd_ptr_q;
  logic [cwq_pkg::CQ_CNT_W-1:0]          cnt_q;
  logic                                  push, pop;

  always_comb begin
    new_cmd.op    = cwq_pkg::cwq_op_e'(opcode_i);
    new_cmd.id    = work_id_i;
    for (int i = 0; i < cwq_pkg::NUM_ITEMS; i++) begin
      new_cmd.id_oh[i] = (int'(work_id_i) == i);
    end
  end

  assign in_ready_o  = (cnt_q != cwq_pkg::CQ_CNT_W'(cwq_pkg::CQ_DEPTH));
  assign cmd_valid_o = (cnt_q != '0);
  assign cmd_o       = cq_q[rd_ptr_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = cmd_pop_i && cmd_valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == cwq_pkg::CQ_PTR_W'(cwq_pkg::CQ_DEPTH - 1)) ?
                    '0 : wr_ptr_q + cwq_pkg::CQ_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == cwq_pkg::CQ_PTR_W'(cwq_pkg::CQ_DEPTH - 1)) ?
                    '0 : rd_ptr_q + cwq_pkg::CQ_PTR_W'(1);
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + cwq_pkg::CQ_CNT_W'(1);
      end else if (pop && !push) begin
        cnt_q <= cnt_q - cwq_pkg::CQ_CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      cq_q[wr_ptr_q] <= new_cmd;
    end
  end

endmodule

`default_nettype wire

### rtl/cwq_back.sv
// ----------------------------------------------------------------------------
// cwq_back: execution back end
// Holds pending bits, the order list, run counts and statistics; executes
// one command step per cycle into the output register unless the output
// stalls; a drain stays at the queue head and dispatches one item per step.
// ----------------------------------------------------------------------------
`default_nettype none

module cwq_back (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cmd_valid_i,
  input  wire cwq_pkg::cwq_cmd_t             cmd_i,
  output logic                               cmd_pop_o,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic                               run_valid_o,
  output logic [cwq_pkg::ID_W-1:0]           run_id_o,
  output logic                               changed_o,
  output logic [cwq_pkg::PEND_W-1:0]         pending_total_o,
  output logic [cwq_pkg::CTR_W-1:0]          item_runs_o,
  output logic [cwq_pkg::CTR_W-1:0]          queued_total_o,
  output logic [cwq_pkg::CTR_W-1:0]          executed_total_o,
  output logic                               last_o
);

  localparam int N = cwq_pkg::NUM_ITEMS;

  logic [N-1:0]                  pending_q, pending_d;
  logic [cwq_pkg::CNT_W-1:0]     count_q, count_d;
  logic [cwq_pkg::CTR_W-1:0]     queued_q, queued_d, executed_q, executed_d;
  logic [cwq_pkg::ID_W-1:0]      order_q [N];
  logic [cwq_pkg::ID_W-1:0]      order_up [N];
  logic [cwq_pkg::CTR_W-1:0]     runs_q [N];
  logic [cwq_pkg::CTR_W-1:0]     runs_sel;
  logic [N-1:0]                  match, cancel_mask, shift_mask, item_oh;
  logic                          pend_hit, load_tail, bump_item, adv;
  logic                          res_run_valid, res_changed, res_last;
  logic [cwq_pkg::ID_W-1:0]      res_run_id;
  logic [cwq_pkg::CTR_W-1:0]     res_runs;
  logic                          out_valid_q;

  assign adv       = cmd_valid_i && (!out_valid_q || out_ready_i);
  assign pend_hit  = |(pending_q & cmd_i.id_oh);
  assign cmd_pop_o = adv && res_last;

  // Locate the cancelled item among the live entries; compact from there up.
  always_comb begin
    for (int j = 0; j < N; j++) begin
      match[j]   = (order_q[j] == cmd_i.id) && (cwq_pkg::CNT_W'(j) < count_q);
      item_oh[j] = (int'(order_q[0]) == j);
    end
    for (int j = 0; j < N; j++) begin
      cancel_mask[j] = |(match & N'((N'(1) << j) - N'(1) | (N'(1) << j)));
    end
    for (int j = 0; j < N - 1; j++) begin
      order_up[j] = order_q[j + 1];
    end
    order_up[N-1] = order_q[N-1];
    runs_sel = '0;
    for (int j = 0; j < N; j++) begin
      runs_sel = runs_sel | (item_oh[j] ? runs_q[j] : '0);
    end
  end

  always_comb begin
    pending_d     = pending_q;
    count_d       = count_q;
    queued_d      = queued_q;
    executed_d    = executed_q;
    shift_mask    = '0;
    load_tail     = 1'b0;
    bump_item     = 1'b0;
    res_run_valid = 1'b0;
    res_run_id    = cmd_i.id;
    res_changed   = 1'b0;
    res_runs      = '0;
    res_last      = 1'b1;
    case (cmd_i.op)
      cwq_pkg::OP_QUEUE: begin
        if ((|cmd_i.id_oh) && !pend_hit && (count_q < cwq_pkg::CNT_W'(N))) begin
          pending_d   = pending_q | cmd_i.id_oh;
          count_d     = count_q + cwq_pkg::CNT_W'(1);
          queued_d    = queued_q + cwq_pkg::CTR_W'(1);
          load_tail   = 1'b1;
          res_changed = 1'b1;
        end
      end
      cwq_pkg::OP_CANCEL: begin
        if (pend_hit) begin
          pending_d   = pending_q & ~cmd_i.id_oh;
          shift_mask  = cancel_mask;
          res_changed = 1'b1;
          if (|match) begin
            count_d = count_q - cwq_pkg::CNT_W'(1);
          end
        end
      end
      cwq_pkg::OP_DRAIN: begin
        if (count_q == '0) begin
          res_run_id = '0;
        end else begin
          // Dispatch the oldest item; hold the command until the list empties.
          shift_mask    = '1;
          pending_d     = pending_q & ~item_oh;
          count_d       = count_q - cwq_pkg::CNT_W'(1);
          executed_d    = executed_q + cwq_pkg::CTR_W'(1);
          bump_item     = 1'b1;
          res_run_valid = 1'b1;
          res_run_id    = order_q[0];
          res_runs      = runs_sel + cwq_pkg::CTR_W'(1);
          res_last      = (count_q == cwq_pkg::CNT_W'(1));
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q   <= '0;
      count_q     <= '0;
      queued_q    <= '0;
      executed_q  <= '0;
      out_valid_q <= 1'b0;
      for (int j = 0; j < N; j++) begin
        runs_q[j] <= '0;
      end
    end else begin
      if (adv) begin
        pending_q   <= pending_d;
        count_q     <= count_d;
        queued_q    <= queued_d;
        executed_q  <= executed_d;
        out_valid_q <= 1'b1;
        for (int j = 0; j < N; j++) begin
          if (bump_item && item_oh[j]) begin
            runs_q[j] <= res_runs;
          end
        end
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int j = 0; j < N; j++) begin
        if (load_tail && (cwq_pkg::CNT_W'(j) == count_q)) begin
          order_q[j] <= cmd_i.id;
        end else if (shift_mask[j]) begin
          order_q[j] <= order_up[j];
        end
      end
      run_valid_o      <= res_run_valid;
      run_id_o         <= res_run_id;
      changed_o        <= res_changed;
      pending_total_o  <= cwq_pkg::PEND_W'(count_d);
      item_runs_o      <= res_runs;
      queued_total_o   <= queued_d;
      executed_total_o <= executed_d;
      last_o           <= res_last;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

### rtl/cwq_checker.sv
// ----------------------------------------------------------------------------
// cwq_port_checks: port-level checks of the coalescing work queue
// Watches the result channel and flags inconsistent results.
// ----------------------------------------------------------------------------
`default_nettype none

module cwq_port_checks (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          out_valid_o,
  input  wire logic                          out_ready_i,
  input  wire logic                          run_valid_o,
  input  wire logic [cwq_pkg::ID_W-1:0]      run_id_o,
  input  wire logic                          changed_o,
  input  wire logic [cwq_pkg::PEND_W-1:0]    pending_total_o,
  input  wire logic [cwq_pkg::CTR_W-1:0]     item_runs_o,
  input  wire logic [cwq_pkg::CTR_W-1:0]     executed_total_o,
  input  wire logic                          last_o
);

  // Hold a stalled result.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(run_id_o) &&
    $stable(item_runs_o) && $stable(last_o) && $stable(pending_total_o))
    else $error("result changed while stalled");

  // A dispatch is last exactly when nothing stays pending.
  a_drain_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && run_valid_o |-> (last_o == (pending_total_o == '0)))
    else $error("drain last flag disagrees with pending count");

  a_single_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !run_valid_o |-> last_o && (item_runs_o == '0))
    else $error("non-dispatch result not final or carries runs");

  a_run_unchanged: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && run_valid_o |-> !changed_o && (item_runs_o != '0))
    else $error("dispatch result flags a change or zero runs");

  // A dispatch leaves the executed count one ahead of the previous dispatch.
  a_exec_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && run_valid_o && !last_o ##1 out_valid_o |->
    run_valid_o && (executed_total_o == $past(executed_total_o) + 32'd1))
    else $error("drain sequence broken");

endmodule

bind coalescing_work_queue cwq_port_checks u_cwq_port_checks (.*);

`default_nettype wire
